FILE: rtl/core/utf8d_pkg.sv
package utf8d_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // One queued job: the results that one input byte causes, one or two of them.
    // A second result is only ever an ASCII character, an invalid mark or a
    // truncation mark, so its code point fits in seven bits.
    typedef struct packed {
        logic        two;
        logic [30:0] cp0;
        logic [1:0]  st0;
        logic [6:0]  cp1;
        logic [1:0]  st1;
    } job_t;

endpackage

FILE: rtl/core/utf8_stream_decoder_31bit_unit.sv
// Streaming UTF-8 decoder for the original 1 to 6 byte form, giving 31-bit code
// points. It takes one byte beat per cycle; each byte yields zero, one or two result
// beats, and last_of_run marks the final result of a byte. A byte that breaks a
// pending sequence gives an invalid result and is then decoded as a new lead byte;
// end_of_stream with a sequence still open gives a truncated result. The front stage
// decodes each byte in the cycle it is accepted and writes its results as one job
// into a QUEUE_DEPTH-entry queue; the back stage drains one result per cycle into
// the output register while out_stall is low. A result passes through the queue
// and then the output register. Input throughput is one byte per cycle, and output
// throughput is one result per cycle, so a byte with two results takes an output
// slot for each. The queue absorbs short bursts of such bytes; a long run of
// them, or a stalled output, fills the queue, and in_stall then holds the input
// until a job drains. No overlong or surrogate checks are made.
module utf8_stream_decoder_31bit_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] code_point,
    output logic [1:0]  status,
    output logic        last_of_run
);
    import utf8d_pkg::*;

    logic push;
    job_t push_job;
    logic q_pop;
    job_t q_job;
    logic q_full;
    logic q_empty;

    utf8d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .data_byte    (data_byte),
        .end_of_stream(end_of_stream),
        .q_full       (q_full),
        .in_stall     (in_stall),
        .push         (push),
        .push_job     (push_job)
    );

    utf8d_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (q_pop),
        .pop_job (q_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    utf8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (q_job),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .status     (status),
        .last_of_run(last_of_run)
    );

    // Only a broken sequence gives two results, and its first one is always invalid.
    a_first_of_two_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> (status == ST_INVALID))
        else $error("first of two results is not an invalid mark");

    // The second result of a byte follows its first without a gap.
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> out_valid)
        else $error("second result of a byte did not follow");

    // Invalid and truncated results carry a zero code point.
    a_error_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (code_point == 31'd0))
        else $error("non-decoded result has a nonzero code point");

    // The queue is never drained while nothing is stored.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

FILE: rtl/core/utf8d_front.sv
module utf8d_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      data_byte,
    input  logic            end_of_stream,
    input  logic            q_full,
    output logic            in_stall,
    output logic            push,
    output utf8d_pkg::job_t push_job
);
    import utf8d_pkg::*;

    logic [30:0] partial_reg;
    logic [30:0] partial_next;
    logic [2:0]  remain_reg;
    logic [2:0]  remain_next;

    logic        accept;
    logic        is_cont;
    logic        take_lead;
    logic        brk;
    logic        lead_res;
    logic [6:0]  lead_cp;
    logic [1:0]  lead_st;
    logic [30:0] lead_bits;
    logic [2:0]  lead_more;
    logic        done_res;
    logic [30:0] done_cp;
    logic        trunc;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign is_cont  = (data_byte[7:6] == 2'b10);

    // Classify the byte as a lead byte: whole character, stray byte or sequence start.
    always_comb
    begin
        lead_cp   = 7'd0;
        lead_st   = ST_OK;
        lead_bits = 31'd0;
        lead_more = 3'd0;
        if (data_byte[7] == 1'b0)
        begin
            lead_cp = data_byte[6:0];
        end
        else if (data_byte inside {[8'h80:8'hBF], [8'hFE:8'hFF]})
        begin
            lead_st = ST_INVALID;
        end
        else if (data_byte >= 8'hFC)
        begin
            lead_bits = {30'd0, data_byte[0]};
            lead_more = 3'd5;
        end
        else if (data_byte >= 8'hF8)
        begin
            lead_bits = {29'd0, data_byte[1:0]};
            lead_more = 3'd4;
        end
        else if (data_byte >= 8'hF0)
        begin
            lead_bits = {28'd0, data_byte[2:0]};
            lead_more = 3'd3;
        end
        else if (data_byte >= 8'hE0)
        begin
            lead_bits = {27'd0, data_byte[3:0]};
            lead_more = 3'd2;
        end
        else
        begin
            lead_bits = {26'd0, data_byte[4:0]};
            lead_more = 3'd1;
        end
    end

    // Sequence state update and the results this byte causes.
    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        take_lead    = 1'b0;
        brk          = 1'b0;
        lead_res     = 1'b0;
        done_res     = 1'b0;
        done_cp      = {partial_reg[24:0], data_byte[5:0]};
        trunc        = 1'b0;

        if (remain_reg == 3'd0)
        begin
            take_lead = 1'b1;
        end
        else if (is_cont)
        begin
            partial_next = done_cp;
            remain_next  = remain_reg - 3'd1;
            if (remain_reg == 3'd1)
            begin
                done_res     = 1'b1;
                partial_next = 31'd0;
            end
        end
        else
        begin
            brk          = 1'b1;
            take_lead    = 1'b1;
            partial_next = 31'd0;
            remain_next  = 3'd0;
        end

        if (take_lead)
        begin
            if (lead_more == 3'd0)
            begin
                lead_res = 1'b1;
            end
            else
            begin
                partial_next = lead_bits;
                remain_next  = lead_more;
            end
        end

        if (end_of_stream && (remain_next != 3'd0))
        begin
            trunc        = 1'b1;
            partial_next = 31'd0;
            remain_next  = 3'd0;
        end
    end

    // Pack the results into one job; only a broken sequence gives two.
    always_comb
    begin
        push_job.two = brk && (lead_res || trunc);
        push_job.cp1 = lead_res ? lead_cp : 7'd0;
        push_job.st1 = lead_res ? lead_st : ST_TRUNC;
        if (brk)
        begin
            push_job.cp0 = 31'd0;
            push_job.st0 = ST_INVALID;
        end
        else if (done_res)
        begin
            push_job.cp0 = done_cp;
            push_job.st0 = ST_OK;
        end
        else if (lead_res)
        begin
            push_job.cp0 = {24'd0, lead_cp};
            push_job.st0 = lead_st;
        end
        else
        begin
            push_job.cp0 = 31'd0;
            push_job.st0 = ST_TRUNC;
        end
    end

    assign push = accept && (brk || done_res || lead_res || trunc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 31'd0;
            remain_reg  <= 3'd0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

FILE: rtl/core/utf8d_queue.sv
module utf8d_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utf8d_pkg::job_t push_job,
    input  logic            pop,
    output utf8d_pkg::job_t pop_job,
    output logic            full,
    output logic            empty
);
    import utf8d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem[rd_ptr_reg];

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/utf8d_back.sv
module utf8d_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  utf8d_pkg::job_t q_job,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [30:0]     code_point,
    output logic [1:0]      status,
    output logic            last_of_run
);
    import utf8d_pkg::*;

    logic        valid_reg;
    logic        pend_reg;
    logic [30:0] cp_reg;
    logic [1:0]  st_reg;
    logic        last_reg;
    logic [6:0]  pend_cp_reg;
    logic [1:0]  pend_st_reg;
    logic        load;

    // The output register can take a new beat when it is empty or being drained.
    assign load  = !valid_reg || !out_stall;
    assign q_pop = load && !pend_reg && !q_empty;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= !q_empty;
                pend_reg  <= !q_empty && q_job.two;
            end
        end
    end

    // Result payload and the held second result of a two-result job.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                cp_reg   <= {24'd0, pend_cp_reg};
                st_reg   <= pend_st_reg;
                last_reg <= 1'b1;
            end
            else if (!q_empty)
            begin
                cp_reg      <= q_job.cp0;
                st_reg      <= q_job.st0;
                last_reg    <= !q_job.two;
                pend_cp_reg <= q_job.cp1;
                pend_st_reg <= q_job.st1;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign code_point  = cp_reg;
    assign status      = st_reg;
    assign last_of_run = last_reg;

endmodule

FILE: sim/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    // A byte beat as the sender offers it.
    typedef struct packed {
        logic [7:0] b;
        logic       eos;
    } stream_beat_t;

    // One decoded result beat.
    typedef struct packed {
        logic [30:0] cp;
        logic [1:0]  st;
        logic        last;
    } decoded_t;

    localparam int RANDOM_BYTES   = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [30:0] code_point;
    logic [1:0]  status;
    logic        last_of_run;

    stream_beat_t pending_beats[$];
    decoded_t     expected_points[$];
    decoded_t     step_results[$];

    // Decoder state mirrored by the predictor.
    logic [30:0] partial_cp = '0;
    logic [2:0]  cont_left = '0;

    int mismatches = 0;
    int idle_cycles = 0;
    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;

    utf8_stream_decoder_31bit_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .status        (status),
        .last_of_run   (last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Gap length: mostly short, a few long, none at all in a calm stretch.
    function automatic int pick_delay(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic add_beat(input logic [7:0] b, input logic eos);
        stream_beat_t beat;
        beat.b = b;
        beat.eos = eos;
        pending_beats.push_back(beat);
    endtask

    task automatic note_result(input logic [30:0] cp, input logic [1:0] st);
        decoded_t res;
        res.cp = cp;
        res.st = st;
        res.last = 1'b0;
        step_results.push_back(res);
    endtask

    // A byte seen while no sequence is open: a character, a stray byte, or a lead.
    task automatic start_lead(input logic [7:0] b);
        if (b < 8'h80)
            note_result({23'd0, b}, ST_OK);
        else if (b >= 8'hFE || b < 8'hC0)
            note_result('0, ST_INVALID);
        else if (b >= 8'hFC)
        begin
            partial_cp = {30'd0, b[0]};
            cont_left = 3'd5;
        end
        else if (b >= 8'hF8)
        begin
            partial_cp = {29'd0, b[1:0]};
            cont_left = 3'd4;
        end
        else if (b >= 8'hF0)
        begin
            partial_cp = {28'd0, b[2:0]};
            cont_left = 3'd3;
        end
        else if (b >= 8'hE0)
        begin
            partial_cp = {27'd0, b[3:0]};
            cont_left = 3'd2;
        end
        else
        begin
            partial_cp = {26'd0, b[4:0]};
            cont_left = 3'd1;
        end
    endtask

    // Sender: offers queued beats with random gaps and predicts each accepted byte.
    always @(posedge clk)
    begin : drive
        stream_beat_t next_beat;
        decoded_t     tail;
        int           gap_left;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                step_results.delete();
                if (cont_left == 3'd0)
                    start_lead(data_byte);
                else if (data_byte[7:6] == 2'b10)
                begin
                    partial_cp = {partial_cp[24:0], data_byte[5:0]};
                    cont_left = cont_left - 3'd1;
                    if (cont_left == 3'd0)
                    begin
                        note_result(partial_cp, ST_OK);
                        partial_cp = '0;
                    end
                end
                else
                begin
                    // Broken sequence: drop it, then treat the byte as a new lead.
                    note_result('0, ST_INVALID);
                    partial_cp = '0;
                    cont_left = 3'd0;
                    start_lead(data_byte);
                end
                if (end_of_stream && cont_left != 3'd0)
                begin
                    note_result('0, ST_TRUNC);
                    partial_cp = '0;
                    cont_left = 3'd0;
                end
                if (step_results.size() > 0)
                begin
                    tail = step_results.pop_back();
                    tail.last = 1'b1;
                    step_results.push_back(tail);
                end
                foreach (step_results[k])
                    expected_points.push_back(step_results[k]);
                if ($urandom_range(0, 49) == 0)
                    sender_calm = !sender_calm;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    next_beat = pending_beats.pop_front();
                    data_byte <= next_beat.b;
                    end_of_stream <= next_beat.eos;
                    in_valid <= 1'b1;
                    gap_left = pick_delay(sender_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result beat and stalls at random, with two long holds.
    always @(posedge clk)
    begin : receive
        decoded_t want;
        int       stall_left;
        int       results_seen;
        int       len;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen = results_seen + 1;
                if (expected_points.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected result, code_point %h status %0d last %0b",
                             $time, code_point, status, last_of_run);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (code_point !== want.cp)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: code_point expected %h, got %h",
                                 $time, want.cp, code_point);
                    end
                    if (status !== want.st)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.st, status);
                    end
                    if (last_of_run !== want.last)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: last_of_run expected %0b, got %0b",
                                 $time, want.last, last_of_run);
                    end
                end
                if (results_seen == 60 || results_seen == 250)
                    stall_left = HOLD_CYCLES;
                if ($urandom_range(0, 49) == 0)
                    receiver_calm = !receiver_calm;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                len = pick_delay(receiver_calm);
                if (len > 0)
                begin
                    stall_left = len - 1;
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          kind;
        int          len;
        int          sent;
        logic [31:0] r;
        logic [7:0]  lead;

        // Directed: single bytes at the edges, stray bytes, longest forms.
        add_beat(8'h00, 1'b0);
        add_beat(8'h7F, 1'b1);
        add_beat(8'h80, 1'b0);
        add_beat(8'hBF, 1'b0);
        add_beat(8'hFE, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'hC0, 1'b0);
        add_beat(8'h80, 1'b0);
        add_beat(8'hDF, 1'b0);
        add_beat(8'hBF, 1'b0);
        add_beat(8'hFD, 1'b0);
        repeat (5) add_beat(8'hBF, 1'b0);
        // Broken sequences: a character and a stray byte arriving mid-sequence.
        add_beat(8'hC3, 1'b0);
        add_beat(8'h41, 1'b0);
        add_beat(8'hE2, 1'b0);
        add_beat(8'hFF, 1'b0);
        // Truncation at stream end, plain and right after a broken sequence.
        add_beat(8'hF0, 1'b0);
        add_beat(8'h90, 1'b1);
        add_beat(8'hC3, 1'b0);
        add_beat(8'hC3, 1'b1);

        // Random part: mostly well-formed sequences, some cut short, some noise.
        while (pending_beats.size() < RANDOM_BYTES + 24)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 82)
            begin
                len = $urandom_range(1, 6);
                sent = len;
                if (len > 1 && $urandom_range(0, 9) == 0)
                    sent = $urandom_range(1, len - 1);
                r = $urandom();
                case (len)
                    1: lead = {1'b0, r[6:0]};
                    2: lead = {3'b110, r[4:0]};
                    3: lead = {4'b1110, r[3:0]};
                    4: lead = {5'b11110, r[2:0]};
                    5: lead = {6'b111110, r[1:0]};
                    default: lead = {7'b1111110, r[0]};
                endcase
                add_beat(lead, $urandom_range(0, 39) == 0);
                for (int k = 1; k < sent; k++)
                begin
                    r = $urandom();
                    add_beat({2'b10, r[5:0]}, $urandom_range(0, 39) == 0);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    r = $urandom();
                    add_beat(r[7:0], $urandom_range(0, 7) == 0);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all beats sent, all results in, then a few quiet cycles.
        while (pending_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
